### src/cts_pkg.sv
`timescale 1ns / 1ps
package cts_pkg;

  localparam int unsigned ThreadSlots   = 8;
  localparam int unsigned MinReplyBytes = 40;
  localparam int unsigned MaxWakeRecs   = 8;

  localparam logic [7:0]  SharedSpace = 8'd255;
  localparam logic [63:0] KernelPsr   = 64'h5;
  localparam logic [63:0] IdlePsr     = 64'h3c0;

  // Input word: action, thread_id, resume_pc, resume_sp, resume_psr, event_id,
  // reply_addr, reply_size, space_slot = 4+16+64*3+10+64+16+8 = 310 -> 312 bits.
  localparam int unsigned InWidth  = 312;
  // Output word: outcome .. woke_event = 3+16+64*3+8+1+64+16+10 = 310 -> 312 bits.
  localparam int unsigned OutWidth = 312;

  typedef enum logic [3:0] {
    ActReset    = 4'd0,
    ActRegister = 4'd1,
    ActMarkRun  = 4'd2,
    ActSetSpace = 4'd3,
    ActSetCur   = 4'd4,
    ActWake     = 4'd5,
    ActEvWake   = 4'd6,
    ActExit     = 4'd7,
    ActBlockMsg = 4'd8,
    ActWaitDev  = 4'd9,
    ActSend     = 4'd10,
    ActIdle     = 4'd11,
    ActQuery    = 4'd12
  } action_e;

  typedef enum logic [2:0] {
    OcDone    = 3'd0,
    OcReject  = 3'd1,
    OcSwitch  = 3'd2,
    OcKernel  = 3'd3,
    OcDeliver = 3'd4,
    OcEvWoke  = 3'd5,
    OcInfo    = 3'd6
  } outcome_e;

  typedef enum logic [2:0] {
    StUnused   = 3'd0,
    StRunnable = 3'd1,
    StRunning  = 3'd2,
    StBlockMsg = 3'd3,
    StBlockDev = 3'd4,
    StExited   = 3'd5
  } status_e;

  localparam logic [0:0] CfgKernelPc = 1'b0;
  localparam logic [0:0] CfgIdlePc   = 1'b1;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] thread_id;
    logic [63:0] resume_pc;
    logic [63:0] resume_sp;
    logic [63:0] resume_psr;
    logic [9:0]  event_id;
    logic [63:0] reply_addr;
    logic [15:0] reply_size;
    logic [7:0]  space_slot;
  } item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [15:0] out_thread;
    logic [63:0] out_pc;
    logic [63:0] out_sp;
    logic [63:0] out_psr;
    logic [7:0]  out_space;
    logic        private_space;
    logic [63:0] deliver_addr;
    logic [15:0] sender_id;
    logic [9:0]  woke_event;
    logic        last;
  } result_t;

  // Slot search kinds, one scan per search.
  typedef enum logic [2:0] {
    SrchStatus,
    SrchId,
    SrchIdStatus,
    SrchWake
  } search_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OpNone,
    OpLoad,
    OpScan,
    OpClear,
    OpApply,
    OpDispatch,
    OpSaveCtx,
    OpWakeStep,
    OpFinish
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    search_e    srch;
    logic [2:0] want;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic wake_hit;
    logic wake_end;
  } dp_sts_t;

endpackage

### src/cooperative_thread_scheduler.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      tdata: one action word
// m_axis    out        m_axis_tvalid/tready      tdata: result, tlast: last
// cfg       in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
// Each slot search walks the table one slot per cycle, and exit or block actions
// search twice.
// An event wake gives one word per woken slot, up to MaxWakeRecs, then a closing word.
// Reset leaves the table empty; no clearing pass is needed.
// A stalled output holds the controller; the next action is taken once the last
// word sits in the output register.
module cooperative_thread_scheduler #(
  parameter int unsigned ThreadSlots   = cts_pkg::ThreadSlots,
  parameter int unsigned MinReplyBytes = cts_pkg::MinReplyBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // action, thread_id, resume_pc, resume_sp, resume_psr, event_id,
  // reply_addr, reply_size, space_slot (from bit 0 up)
  input  logic [cts_pkg::InWidth-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // outcome, out_thread, out_pc, out_sp, out_psr, out_space, private_space,
  // deliver_addr, sender_id, woke_event (from bit 0 up)
  output logic [cts_pkg::OutWidth-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [63:0]                   cfg_data_i
);
  import cts_pkg::*;

  item_t   item;
  dp_cmd_t cmd;
  dp_sts_t sts;
  result_t res;
  logic    res_load, res_last, ov_q;
  logic [63:0] kpc_q, ipc_q;
  logic [OutWidth-1:0] od_q;
  logic    ol_q;

  assign item.action     = s_axis_tdata[3:0];
  assign item.thread_id  = s_axis_tdata[19:4];
  assign item.resume_pc  = s_axis_tdata[83:20];
  assign item.resume_sp  = s_axis_tdata[147:84];
  assign item.resume_psr = s_axis_tdata[211:148];
  assign item.event_id   = s_axis_tdata[221:212];
  assign item.reply_addr = s_axis_tdata[285:222];
  assign item.reply_size = s_axis_tdata[301:286];
  assign item.space_slot = s_axis_tdata[309:302];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kpc_q <= '0;
      ipc_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgKernelPc) kpc_q <= cfg_data_i;
      else ipc_q <= cfg_data_i;
    end
  end

  cts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (s_axis_tdata[3:0]),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .res_load_o (res_load),
    .res_last_o (res_last),
    .res_free_i (!ov_q || m_axis_tready)
  );

  cts_datapath #(
    .ThreadSlots(ThreadSlots), .MinReplyBytes(MinReplyBytes)
  ) u_dp (
    .clk_i, .rst_ni,
    .item_i      (item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kernel_pc_i (kpc_q),
    .idle_pc_i   (ipc_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (res_load) begin
      ov_q <= 1'b1;
    end else if (m_axis_tready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      od_q <= {2'b0, res.woke_event, res.sender_id, res.deliver_addr,
               res.private_space, res.out_space, res.out_psr, res.out_sp,
               res.out_pc, res.out_thread, res.outcome};
      ol_q <= res_last;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;

endmodule

### src/cts_ctrl.sv
`timescale 1ns / 1ps
module cts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [3:0]       action_i,
  input  cts_pkg::dp_sts_t sts_i,
  output cts_pkg::dp_cmd_t cmd_o,
  output logic             res_load_o,
  output logic             res_last_o,
  input  logic             res_free_i
);
  import cts_pkg::*;

  typedef enum logic [2:0] {
    SIdle, SScan, SDisp, SApply, SWake, SEmit, SEmitWake
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] act_q, act_d;
  logic       disp_q, disp_d;

  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    disp_d     = disp_q;
    cmd_o      = '{op: OpNone, srch: SrchStatus, want: StUnused};
    res_load_o = 1'b0;
    res_last_o = 1'b1;
    in_ready_o = (state_q == SIdle);
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.op = OpLoad;
          act_d    = action_i;
          disp_d   = 1'b0;
          state_d  = SScan;
        end
      end
      SScan: begin
        cmd_o.op = OpScan;
        case (act_q)
          ActRegister: cmd_o.srch = SrchStatus;
          ActMarkRun: begin
            cmd_o.srch = SrchIdStatus;
            cmd_o.want = StRunnable;
          end
          ActWake: begin
            cmd_o.srch = SrchIdStatus;
            cmd_o.want = StBlockDev;
          end
          ActSend: begin
            cmd_o.srch = SrchIdStatus;
            cmd_o.want = StBlockMsg;
          end
          ActSetSpace, ActQuery: cmd_o.srch = SrchId;
          ActExit, ActBlockMsg, ActWaitDev: cmd_o.want = StRunning;
          ActIdle: cmd_o.want = StRunnable;
          default: cmd_o.srch = SrchStatus;
        endcase
        if (act_q == ActEvWake) begin
          cmd_o.op = OpNone;
          state_d  = SWake;
        end else if (sts_i.scan_done) begin
          state_d = SApply;
        end
      end
      SApply: begin
        cmd_o.op = OpApply;
        if (act_q == ActExit || act_q == ActBlockMsg || act_q == ActWaitDev) begin
          state_d = SDisp;
          disp_d  = 1'b1;
        end else begin
          state_d = SEmit;
        end
      end
      SDisp: begin
        // Second scan for the lowest runnable slot.
        cmd_o.op   = disp_q ? OpScan : OpDispatch;
        cmd_o.want = StRunnable;
        if (disp_q && sts_i.scan_done) disp_d = 1'b0;
        if (!disp_q) state_d = SEmit;
      end
      SWake: begin
        cmd_o.op = OpWakeStep;
        if (sts_i.wake_hit) state_d = SEmitWake;
        else if (sts_i.wake_end) state_d = SEmit;
      end
      SEmitWake: begin
        if (res_free_i) begin
          res_load_o = 1'b1;
          res_last_o = 1'b0;
          cmd_o.op   = OpFinish;
          state_d    = SWake;
        end
      end
      SEmit: begin
        if (res_free_i) begin
          res_load_o = 1'b1;
          cmd_o.op   = OpFinish;
          state_d    = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      act_q   <= '0;
      disp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      disp_q  <= disp_d;
    end
  end

endmodule

### src/cts_datapath.sv
`timescale 1ns / 1ps
module cts_datapath #(
  parameter int unsigned ThreadSlots   = cts_pkg::ThreadSlots,
  parameter int unsigned MinReplyBytes = cts_pkg::MinReplyBytes
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cts_pkg::item_t   item_i,
  input  cts_pkg::dp_cmd_t cmd_i,
  output cts_pkg::dp_sts_t sts_o,
  input  logic [63:0]      kernel_pc_i,
  input  logic [63:0]      idle_pc_i,
  output cts_pkg::result_t res_o
);
  import cts_pkg::*;

  localparam int unsigned IdxW = $clog2(ThreadSlots);
  localparam int unsigned CntW = $clog2(ThreadSlots + 1);

  logic [15:0] thr_q [ThreadSlots];
  logic [2:0]  st_q  [ThreadSlots];
  logic [63:0] pc_q  [ThreadSlots];
  logic [63:0] sp_q  [ThreadSlots];
  logic [63:0] psr_q [ThreadSlots];
  logic [63:0] ra_q  [ThreadSlots];
  logic [15:0] rs_q  [ThreadSlots];
  logic [9:0]  ev_q  [ThreadSlots];
  logic [7:0]  spc_q [ThreadSlots];

  item_t       it_q;
  logic [15:0] run_q, cur_q;
  logic        msg_q;
  logic [CntW-1:0] ptr_q;
  logic [IdxW-1:0] hit_q;
  logic        found_q;
  logic [3:0]  nwake_q;
  result_t     res_q;

  logic [IdxW-1:0] p;
  logic            match, done_scan, evm;
  assign p         = ptr_q[IdxW-1:0];
  assign done_scan = (ptr_q == CntW'(ThreadSlots)) || found_q;
  assign evm       = (st_q[p] == StBlockDev) && (ev_q[p] == 10'd0 || ev_q[p] == it_q.event_id);

  always_comb begin
    case (cmd_i.srch)
      SrchId:       match = thr_q[p] == it_q.thread_id;
      SrchIdStatus: match = (thr_q[p] == it_q.thread_id) && (st_q[p] == cmd_i.want);
      default:      match = st_q[p] == cmd_i.want;
    endcase
  end

  assign sts_o.scan_done = done_scan;
  assign sts_o.found     = found_q;
  assign sts_o.wake_hit  = (ptr_q != CntW'(ThreadSlots)) && evm && (nwake_q < 4'(MaxWakeRecs));
  assign sts_o.wake_end  = ptr_q == CntW'(ThreadSlots);
  assign res_o           = res_q;

  function automatic result_t blank(input logic [2:0] oc);
    result_t r;
    r           = '0;
    r.outcome   = oc;
    r.out_space = SharedSpace;
    r.last      = 1'b1;
    return r;
  endfunction

  function automatic result_t switch_word(input logic [IdxW-1:0] i, input logic [63:0] psr);
    result_t r;
    r               = blank(OcSwitch);
    r.out_thread    = thr_q[i];
    r.out_pc        = pc_q[i];
    r.out_sp        = sp_q[i];
    r.out_psr       = psr;
    r.out_space     = spc_q[i];
    r.private_space = spc_q[i] != SharedSpace;
    return r;
  endfunction

  function automatic result_t info_word(input logic [IdxW-1:0] i);
    result_t r;
    r            = blank(OcInfo);
    r.out_thread = thr_q[i];
    r.out_pc     = pc_q[i];
    r.out_sp     = sp_q[i];
    r.out_psr    = psr_q[i];
    r.out_space  = spc_q[i];
    return r;
  endfunction

  function automatic result_t deliver_word(input logic [IdxW-1:0] i);
    result_t r;
    r              = blank(OcDeliver);
    r.out_thread   = thr_q[i];
    r.deliver_addr = ra_q[i];
    r.sender_id    = cur_q;
    return r;
  endfunction

  function automatic result_t kernel_word(input logic [63:0] pc, input logic [63:0] sp);
    result_t r;
    r         = blank(OcKernel);
    r.out_pc  = pc;
    r.out_sp  = sp;
    r.out_psr = KernelPsr;
    return r;
  endfunction

  function automatic result_t woke_word(input logic [IdxW-1:0] i);
    result_t r;
    r            = blank(OcEvWoke);
    r.out_thread = thr_q[i];
    r.woke_event = it_q.event_id;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ThreadSlots; i++) begin
        thr_q[i] <= '0;
        st_q[i]  <= StUnused;
        ra_q[i]  <= '0;
        rs_q[i]  <= '0;
        ev_q[i]  <= '0;
        spc_q[i] <= SharedSpace;
      end
      run_q   <= '0;
      cur_q   <= 16'd1;
      msg_q   <= 1'b0;
      ptr_q   <= '0;
      hit_q   <= '0;
      found_q <= 1'b0;
      nwake_q <= '0;
      res_q   <= '0;
    end else begin
      case (cmd_i.op)
        OpLoad: begin
          it_q    <= item_i;
          ptr_q   <= '0;
          found_q <= 1'b0;
          nwake_q <= '0;
          res_q   <= blank(OcDone);
        end
        OpScan: begin
          if (done_scan) begin
            ptr_q <= '0;
          end else begin
            if (match) begin
              found_q <= 1'b1;
              hit_q   <= p;
            end else begin
              ptr_q <= ptr_q + 1'b1;
            end
          end
        end
        OpApply: begin
          found_q <= 1'b0;
          ptr_q   <= '0;
          case (it_q.action)
            ActReset: begin
              for (int i = 0; i < ThreadSlots; i++) begin
                thr_q[i] <= '0;
                st_q[i]  <= StUnused;
                ra_q[i]  <= '0;
                rs_q[i]  <= '0;
                ev_q[i]  <= '0;
                spc_q[i] <= SharedSpace;
              end
              run_q <= '0;
              msg_q <= 1'b0;
            end
            ActRegister: begin
              if (!found_q) res_q <= blank(OcReject);
              else begin
                thr_q[hit_q] <= it_q.thread_id;
                st_q[hit_q]  <= StRunnable;
                pc_q[hit_q]  <= it_q.resume_pc;
                sp_q[hit_q]  <= it_q.resume_sp;
                psr_q[hit_q] <= it_q.resume_psr;
                ra_q[hit_q]  <= '0;
                rs_q[hit_q]  <= '0;
              end
            end
            ActMarkRun: begin
              if (!found_q) res_q <= blank(OcReject);
              else begin
                st_q[hit_q] <= StRunning;
                run_q       <= it_q.thread_id;
              end
            end
            ActSetSpace: begin
              if (!found_q) res_q <= blank(OcReject);
              else spc_q[hit_q] <= it_q.space_slot;
            end
            ActSetCur: cur_q <= it_q.thread_id;
            ActWake: begin
              if (!found_q) res_q <= blank(OcReject);
              else st_q[hit_q] <= StRunnable;
            end
            ActExit: begin
              if (run_q != 16'd0) begin
                if (found_q) st_q[hit_q] <= StExited;
                run_q <= '0;
              end
            end
            ActBlockMsg, ActWaitDev: begin
              if (!found_q) begin
                res_q <= blank(OcReject);
                // A rejected block skips the dispatch; mark it through the act.
                it_q.action <= ActSetCur;
              end else begin
                pc_q[hit_q]  <= it_q.resume_pc;
                sp_q[hit_q]  <= it_q.resume_sp;
                psr_q[hit_q] <= it_q.resume_psr;
                if (it_q.action == ActBlockMsg) begin
                  ra_q[hit_q] <= it_q.reply_addr;
                  rs_q[hit_q] <= it_q.reply_size;
                  st_q[hit_q] <= StBlockMsg;
                end else begin
                  ev_q[hit_q] <= it_q.event_id;
                  st_q[hit_q] <= StBlockDev;
                end
              end
            end
            ActSend: begin
              if (found_q && ra_q[hit_q] != 64'd0 &&
                  rs_q[hit_q] >= 16'(MinReplyBytes)) begin
                res_q       <= deliver_word(hit_q);
                st_q[hit_q] <= StRunnable;
                msg_q       <= 1'b1;
              end
            end
            ActIdle: begin
              if (found_q) begin
                st_q[hit_q] <= StRunning;
                run_q       <= thr_q[hit_q];
                cur_q       <= thr_q[hit_q];
                res_q       <= switch_word(hit_q, IdlePsr);
              end
            end
            ActQuery: begin
              if (!found_q) res_q <= blank(OcReject);
              else res_q <= info_word(hit_q);
            end
            default: res_q <= blank(OcReject);
          endcase
        end
        OpDispatch: begin
          if (it_q.action == ActSetCur) begin
            // Rejected block: result already set; only the action field is written, to ActBlockMsg.
            it_q.action <= ActBlockMsg;
          end else if (found_q) begin
            st_q[hit_q] <= StRunning;
            run_q       <= thr_q[hit_q];
            cur_q       <= thr_q[hit_q];
            res_q       <= switch_word(hit_q, psr_q[hit_q]);
          end else begin
            if (it_q.action != ActExit) run_q <= '0;
            res_q <= kernel_word((it_q.action == ActWaitDev && idle_pc_i != 64'd0)
                                 ? idle_pc_i : kernel_pc_i, it_q.resume_sp);
          end
        end
        OpWakeStep: begin
          if (ptr_q != CntW'(ThreadSlots)) begin
            if (evm) begin
              st_q[p] <= StRunnable;
              if (nwake_q < 4'(MaxWakeRecs)) begin
                res_q   <= woke_word(p);
                nwake_q <= nwake_q + 4'd1;
              end
            end
            ptr_q <= ptr_q + 1'b1;
          end else begin
            res_q <= blank(OcDone);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### src/cts_checker.sv
`timescale 1ns / 1ps
module cts_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast,
  input logic [2:0] outcome
);
  import cts_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output dropped");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("accept twice");
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> outcome <= OcInfo) else $error("bad outcome");
  a_wake_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> outcome == OcEvWoke) else $error("bad tail");
endmodule

bind cooperative_thread_scheduler cts_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tlast, .outcome(m_axis_tdata[2:0])
);

### tb/cooperative_thread_scheduler_test.sv
`timescale 1ns / 1ps
module cooperative_thread_scheduler_test;
  import cts_pkg::*;

  typedef struct {
    logic [3:0]  act;
    logic [15:0] tid;
    logic [63:0] pc;
    logic [63:0] sp;
    logic [63:0] psr;
    logic [9:0]  ev;
    logic [63:0] raddr;
    logic [15:0] rsize;
    logic [7:0]  space;
  } sched_req_t;

  typedef struct {
    logic [2:0]  oc;
    logic [15:0] thr;
    logic [63:0] pc;
    logic [63:0] sp;
    logic [63:0] psr;
    logic [7:0]  spc;
    logic        prv;
    logic [63:0] daddr;
    logic [15:0] snd;
    logic [9:0]  wev;
    logic        last;
  } sched_word_t;

  class sched_scoreboard;
    logic [63:0] kernel_pc, idle_pc;
    logic [15:0] slot_tid[ThreadSlots];
    status_e     slot_st[ThreadSlots];
    logic [63:0] slot_pc[ThreadSlots], slot_sp[ThreadSlots], slot_psr[ThreadSlots];
    logic [63:0] slot_raddr[ThreadSlots];
    logic [15:0] slot_rsize[ThreadSlots];
    logic [9:0]  slot_wev[ThreadSlots];
    logic [7:0]  slot_space[ThreadSlots];
    logic [15:0] running_tid, current_tid;
    bit          delivered;
    sched_word_t pending_words[$];
    int          errors;

    function new();
      kernel_pc = '0;
      idle_pc = '0;
      clear_table();
      current_tid = 16'd1;
      errors = 0;
    endfunction

    function void clear_table();
      for (int i = 0; i < ThreadSlots; i++) begin
        slot_tid[i] = '0;
        slot_st[i] = StUnused;
        slot_pc[i] = '0;
        slot_sp[i] = '0;
        slot_psr[i] = '0;
        slot_raddr[i] = '0;
        slot_rsize[i] = '0;
        slot_wev[i] = '0;
        slot_space[i] = SharedSpace;
      end
      running_tid = '0;
      delivered = 0;
    endfunction

    function void set_reg(logic idx, logic [63:0] val);
      if (idx == CfgKernelPc) kernel_pc = val;
      else idle_pc = val;
    endfunction

    function sched_word_t blank(outcome_e oc);
      sched_word_t w;
      w = '{default: '0};
      w.oc = oc;
      w.spc = SharedSpace;
      return w;
    endfunction

    function int lowest_with(status_e st);
      for (int i = 0; i < ThreadSlots; i++)
        if (slot_st[i] == st) return i;
      return -1;
    endfunction

    function int lowest_id(logic [15:0] tid, bit any, status_e st);
      for (int i = 0; i < ThreadSlots; i++)
        if (slot_tid[i] == tid && (any || slot_st[i] == st)) return i;
      return -1;
    endfunction

    function bit pick_next(output sched_word_t w, input bit idle);
      int i;
      w = blank(OcDone);
      i = lowest_with(StRunnable);
      if (i < 0) return 0;
      slot_st[i] = StRunning;
      running_tid = slot_tid[i];
      current_tid = slot_tid[i];
      w = blank(OcSwitch);
      w.thr = slot_tid[i];
      w.pc = slot_pc[i];
      w.sp = slot_sp[i];
      w.psr = idle ? IdlePsr : slot_psr[i];
      w.spc = slot_space[i];
      w.prv = slot_space[i] != SharedSpace;
      return 1;
    endfunction

    function sched_word_t to_kernel(logic [63:0] pc, logic [63:0] sp);
      sched_word_t w;
      w = blank(OcKernel);
      w.pc = pc;
      w.sp = sp;
      w.psr = KernelPsr;
      return w;
    endfunction

    function void note_action(sched_req_t r);
      sched_word_t w[$];
      sched_word_t x;
      int i;
      x = blank(OcDone);
      case (r.act)
        ActReset: clear_table();
        ActRegister: begin
          i = lowest_with(StUnused);
          if (i < 0) x.oc = OcReject;
          else begin
            slot_tid[i] = r.tid;
            slot_st[i] = StRunnable;
            slot_pc[i] = r.pc;
            slot_sp[i] = r.sp;
            slot_psr[i] = r.psr;
            slot_raddr[i] = '0;
            slot_rsize[i] = '0;
          end
        end
        ActMarkRun: begin
          i = lowest_id(r.tid, 0, StRunnable);
          if (i < 0) x.oc = OcReject;
          else begin
            slot_st[i] = StRunning;
            running_tid = r.tid;
          end
        end
        ActSetSpace: begin
          i = lowest_id(r.tid, 1, StUnused);
          if (i < 0) x.oc = OcReject;
          else slot_space[i] = r.space;
        end
        ActSetCur: current_tid = r.tid;
        ActWake: begin
          i = lowest_id(r.tid, 0, StBlockDev);
          if (i < 0) x.oc = OcReject;
          else slot_st[i] = StRunnable;
        end
        ActEvWake: begin
          for (int k = 0; k < ThreadSlots; k++) begin
            if (slot_st[k] == StBlockDev && (slot_wev[k] == 0 || slot_wev[k] == r.ev)) begin
              slot_st[k] = StRunnable;
              if (w.size() < MaxWakeRecs) begin
                sched_word_t y;
                y = blank(OcEvWoke);
                y.thr = slot_tid[k];
                y.wev = r.ev;
                w.push_back(y);
              end
            end
          end
        end
        ActExit: begin
          if (running_tid != 0) begin
            i = lowest_with(StRunning);
            if (i >= 0) slot_st[i] = StExited;
            running_tid = '0;
          end
          if (!pick_next(x, 0)) x = to_kernel(kernel_pc, r.sp);
        end
        ActBlockMsg, ActWaitDev: begin
          i = lowest_with(StRunning);
          if (i < 0) x.oc = OcReject;
          else begin
            slot_pc[i] = r.pc;
            slot_sp[i] = r.sp;
            slot_psr[i] = r.psr;
            if (r.act == ActBlockMsg) begin
              slot_raddr[i] = r.raddr;
              slot_rsize[i] = r.rsize;
              slot_st[i] = StBlockMsg;
            end else begin
              slot_wev[i] = r.ev;
              slot_st[i] = StBlockDev;
            end
            if (!pick_next(x, 0)) begin
              running_tid = '0;
              x = to_kernel((r.act == ActWaitDev && idle_pc != 0) ? idle_pc : kernel_pc,
                            r.sp);
            end
          end
        end
        ActSend: begin
          i = lowest_id(r.tid, 0, StBlockMsg);
          if (i >= 0 && slot_raddr[i] != 0 && slot_rsize[i] >= MinReplyBytes) begin
            x = blank(OcDeliver);
            x.thr = slot_tid[i];
            x.daddr = slot_raddr[i];
            x.snd = current_tid;
            slot_st[i] = StRunnable;
            delivered = 1;
          end
        end
        ActIdle: void'(pick_next(x, 1));
        ActQuery: begin
          i = lowest_id(r.tid, 1, StUnused);
          if (i < 0) x.oc = OcReject;
          else begin
            x = blank(OcInfo);
            x.thr = slot_tid[i];
            x.pc = slot_pc[i];
            x.sp = slot_sp[i];
            x.psr = slot_psr[i];
            x.spc = slot_space[i];
          end
        end
        default: x.oc = OcReject;
      endcase
      w.push_back(x);
      w[w.size()-1].last = 1;
      foreach (w[k]) pending_words.push_back(w[k]);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task check_word(logic [OutWidth-1:0] d, logic tlast);
      sched_word_t e;
      if (pending_words.size() == 0) begin
        report("unexpected word", d[63:0], '0);
        return;
      end
      e = pending_words.pop_front();
      if (d[2:0] !== e.oc) report("outcome", d[2:0], e.oc);
      if (d[18:3] !== e.thr) report("out_thread", d[18:3], e.thr);
      if (d[82:19] !== e.pc) report("out_pc", d[82:19], e.pc);
      if (d[146:83] !== e.sp) report("out_sp", d[146:83], e.sp);
      if (d[210:147] !== e.psr) report("out_psr", d[210:147], e.psr);
      if (d[218:211] !== e.spc) report("out_space", d[218:211], e.spc);
      if (d[219] !== e.prv) report("private_space", d[219], e.prv);
      if (d[283:220] !== e.daddr) report("deliver_addr", d[283:220], e.daddr);
      if (d[299:284] !== e.snd) report("sender_id", d[299:284], e.snd);
      if (d[309:300] !== e.wev) report("woke_event", d[309:300], e.wev);
      if (tlast !== e.last) report("tlast", tlast, e.last);
    endtask
  endclass

  localparam int IdleLimit = 20000;

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                s_axis_tvalid = 0;
  logic                s_axis_tready;
  logic [InWidth-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 0;
  logic [OutWidth-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid_i = 0;
  logic                cfg_ready_o;
  logic                cfg_index_i = 0;
  logic [63:0]         cfg_data_i = '0;

  sched_scoreboard sb = new();
  int quiet_cycles = 0;
  int burst_left = 0;
  bit stalling = 0;

  cooperative_thread_scheduler u_dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Receiver: long stretches of full readiness alternate with random stalls.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stalling = !stalling;
    m_axis_tready <= stalling ? ($urandom_range(0, 2) == 0) : 1'b1;
  end

  always @(posedge clk_i) begin
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
    if (quiet_cycles >= IdleLimit) begin
      $display("cooperative_thread_scheduler_test: FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic sched_req_t mk(logic [3:0] act, logic [15:0] tid);
    sched_req_t r;
    r.act = act;
    r.tid = tid;
    r.pc = rand64();
    r.sp = rand64();
    r.psr = rand64();
    r.ev = 10'($urandom_range(0, 1023));
    r.raddr = rand64();
    r.rsize = 16'($urandom_range(0, 65535));
    r.space = 8'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic send_action(sched_req_t r);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    s_axis_tdata = {2'b00, r.space, r.rsize, r.raddr, r.ev, r.psr, r.sp, r.pc, r.tid, r.act};
    s_axis_tvalid = 1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_action(r);
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 0;
  endtask

  task automatic write_reg(logic idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = val;
    cfg_valid_i = 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  task automatic drain();
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (2 * ThreadSlots + 10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic sched_req_t rand_req();
    sched_req_t r;
    int pick;
    logic [15:0] tid;
    tid = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                      : 16'($urandom_range(1, 4));
    pick = $urandom_range(0, 99);
    if (pick < 15) r = mk(ActRegister, tid);
    else if (pick < 22) r = mk(ActMarkRun, tid);
    else if (pick < 32) begin
      r = mk(ActBlockMsg, tid);
      case ($urandom_range(0, 3))
        0: r.rsize = 16'(MinReplyBytes);
        1: r.rsize = 16'(MinReplyBytes - 1);
        default: ;
      endcase
      if ($urandom_range(0, 5) == 0) r.raddr = '0;
    end else if (pick < 41) begin
      r = mk(ActWaitDev, tid);
      if ($urandom_range(0, 2) != 0) r.ev = 10'($urandom_range(0, 3));
    end else if (pick < 48) begin
      r = mk(ActEvWake, tid);
      if ($urandom_range(0, 2) != 0) r.ev = 10'($urandom_range(0, 3));
    end else if (pick < 53) r = mk(ActWake, tid);
    else if (pick < 63) r = mk(ActSend, tid);
    else if (pick < 71) r = mk(ActExit, tid);
    else if (pick < 77) r = mk(ActIdle, tid);
    else if (pick < 84) r = mk(ActQuery, tid == 0 ? 16'd1 : tid);
    else if (pick < 89) r = mk(ActSetSpace, tid);
    else if (pick < 94) r = mk(ActSetCur, tid);
    else if (pick < 97) r = mk(ActReset, tid);
    else r = mk(4'($urandom_range(13, 15)), tid);
    return r;
  endfunction

  task automatic directed();
    sched_req_t r;
    r = mk(ActRegister, 16'hffff);
    r.pc = '1; r.sp = '1; r.psr = '1;
    send_action(r);
    send_action(mk(ActRegister, 16'd1));
    send_action(mk(ActQuery, 16'hffff));
    r = mk(ActSetSpace, 16'hffff); r.space = 8'd7; send_action(r);
    r = mk(ActSetSpace, 16'd1); r.space = SharedSpace; send_action(r);
    send_action(mk(ActSetSpace, 16'd99));
    send_action(mk(ActMarkRun, 16'd1));
    r = mk(ActBlockMsg, 16'd0); r.raddr = 64'h1000; r.rsize = 16'(MinReplyBytes);
    send_action(r);
    send_action(mk(ActSend, 16'd1));
    r = mk(ActWaitDev, 16'd0); r.ev = 10'd1023; send_action(r);
    r = mk(ActEvWake, 16'd0); r.ev = 10'd5; send_action(r);
    r = mk(ActEvWake, 16'd0); r.ev = 10'd1023; send_action(r);
    send_action(mk(ActIdle, 16'd0));
    r = mk(ActBlockMsg, 16'd0); r.raddr = 64'h2000; r.rsize = 16'(MinReplyBytes - 1);
    send_action(r);
    send_action(mk(ActSend, 16'hffff));
    send_action(mk(ActWake, 16'd42));
    send_action(mk(ActExit, 16'd0));
    send_action(mk(ActExit, 16'd0));
    for (int i = 0; i < ThreadSlots; i++) send_action(mk(ActRegister, 16'(i + 2)));
    send_action(mk(4'd13, 16'd0));
    send_action(mk(4'd15, 16'd0));
    send_action(mk(ActSetCur, 16'd0));
    send_action(mk(ActReset, 16'd0));
    send_action(mk(ActIdle, 16'd0));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    write_reg(CfgKernelPc, '1);
    write_reg(CfgIdlePc, '0);
    directed();
    for (int i = 0; i < 30; i++) send_action(rand_req());
    drain();
    write_reg(CfgKernelPc, {$urandom(), $urandom()});
    write_reg(CfgIdlePc, {$urandom(), $urandom()});
    for (int i = 0; i < 30; i++) send_action(rand_req());
    drain();
    write_reg(CfgKernelPc, '0);
    write_reg(CfgIdlePc, '1);
    for (int i = 0; i < 30; i++) send_action(rand_req());
    drain();
    if (sb.errors == 0 && sb.pending_words.size() == 0)
      $display("cooperative_thread_scheduler_test: PASS");
    else
      $display("cooperative_thread_scheduler_test: FAIL");
    $finish;
  end

endmodule

### sim.f
src/cts_pkg.sv
src/cts_ctrl.sv
src/cts_datapath.sv
src/cooperative_thread_scheduler.sv
src/cts_checker.sv
tb/cooperative_thread_scheduler_test.sv
